// ----- rtl/bas_pkg.sv -----
// Shared types, codes and reset constants for the beep and alert sequencer.
package bas_pkg;

  localparam int QUEUE_LIMIT_DEF = 16;
  localparam int LINK_COUNT_DEF  = 2;

  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int TICK_W      = 8;
  localparam int PULSE_TOT_W = 4;
  localparam int PULSE_W     = 3;
  localparam int WAITING_W   = 5;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_ON     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_GAP    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALERT_ON    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALERT_GAP   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_TOTAL = 3'd4;

  // Configuration values after reset.
  localparam logic [TICK_W-1:0]      BEEP_ON_RST     = 8'd6;
  localparam logic [TICK_W-1:0]      BEEP_GAP_RST    = 8'd4;
  localparam logic [TICK_W-1:0]      ALERT_ON_RST    = 8'd18;
  localparam logic [TICK_W-1:0]      ALERT_GAP_RST   = 8'd12;
  localparam logic [PULSE_TOT_W-1:0] PULSE_TOTAL_RST = 4'd3;
  localparam logic [PULSE_TOT_W-1:0] PULSE_TOTAL_MAX = 4'd8;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_BEEP = 2'd1,
    OP_LINK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BEEP_NONE    = 2'd0,
    BEEP_ACCEPT  = 2'd1,
    BEEP_REFUSED = 2'd2
  } beep_result_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_BEEP_ON   = 5'b00010,
    PH_BEEP_GAP  = 5'b00100,
    PH_ALERT_ON  = 5'b01000,
    PH_ALERT_GAP = 5'b10000
  } phase_t;

endpackage

// ----- rtl/beep_and_alert_sequencer.sv -----
// Beep and alert sequencer: event decode, phase sequencer and result register.
// The result word of an accepted input word is registered and shown in the cycle after acceptance.
// Throughput: one word per cycle; all state updates in a single pass of
// short logic, and in_ready only drops while a result waits on a stalled output.
// Reset (rst, synchronous, active high) returns the sequencer to idle, clears
// the beep count, alert flags and link states, and reloads the default timings.
module beep_and_alert_sequencer #(
  parameter int QUEUE_LIMIT = bas_pkg::QUEUE_LIMIT_DEF,
  parameter int LINK_COUNT  = bas_pkg::LINK_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_write,
  input  logic [bas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bas_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Event input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      operation,
  input  logic [1:0]                      link_index,
  input  logic                            link_up,
  // Result output channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            buzzer_on,
  output logic [1:0]                      beep_result,
  output logic                            alert_sounding,
  output logic [bas_pkg::WAITING_W-1:0]   beeps_waiting
);
  import bas_pkg::*;

  localparam int CNT_W      = $clog2(QUEUE_LIMIT + 1);
  localparam int LINK_IDX_W = $clog2(LINK_COUNT);

  // Timing configuration.
  logic [TICK_W-1:0]      beep_on_ticks;
  logic [TICK_W-1:0]      beep_gap_ticks;
  logic [TICK_W-1:0]      alert_on_ticks;
  logic [TICK_W-1:0]      alert_gap_ticks;
  logic [PULSE_TOT_W-1:0] alert_pulse_total;

  // Sequencer state.
  phase_t                 phase_now, phase_next;
  logic [TICK_W-1:0]      ticks_remaining, ticks_remaining_next;
  logic [PULSE_W-1:0]     pulses_remaining, pulses_remaining_next;
  logic [CNT_W-1:0]       beep_queue_count, beep_queue_count_next;
  logic                   alert_requested, alert_requested_next;
  logic                   alert_in_progress, alert_in_progress_next;
  logic                   outage_latched, outage_latched_next;
  logic [LINK_COUNT-1:0]  link_state, link_state_next;
  beep_result_t           result_next;

  logic                   accept;
  logic [PULSE_TOT_W-1:0] pulse_total_clamped;
  logic                   link_lost;

  // A new word is taken whenever the result register is empty or being drained,
  // so a waiting result never blocks the input for more than the stall itself.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Alert pulse count is held to the range one to eight.
  always_comb begin
    if (alert_pulse_total == '0) begin
      pulse_total_clamped = PULSE_TOT_W'(1);
    end else if (alert_pulse_total > PULSE_TOTAL_MAX) begin
      pulse_total_clamped = PULSE_TOTAL_MAX;
    end else begin
      pulse_total_clamped = alert_pulse_total;
    end
  end

  // Next-state logic for one event.
  always_comb begin
    phase_next             = phase_now;
    ticks_remaining_next   = ticks_remaining;
    pulses_remaining_next  = pulses_remaining;
    beep_queue_count_next  = beep_queue_count;
    alert_requested_next   = alert_requested;
    alert_in_progress_next = alert_in_progress;
    outage_latched_next    = outage_latched;
    link_state_next        = link_state;
    result_next            = BEEP_NONE;
    link_lost              = 1'b0;

    case (op_t'(operation))
      OP_TICK: begin
        if (phase_now != PH_IDLE && ticks_remaining > TICK_W'(1)) begin
          // The current phase still has time left.
          ticks_remaining_next = ticks_remaining - TICK_W'(1);
        end else if (phase_now == PH_BEEP_ON) begin
          phase_next           = PH_BEEP_GAP;
          ticks_remaining_next = beep_gap_ticks;
        end else if (phase_now == PH_ALERT_ON) begin
          phase_next           = PH_ALERT_GAP;
          ticks_remaining_next = alert_gap_ticks;
        end else if (phase_now == PH_ALERT_GAP && pulses_remaining != '0) begin
          pulses_remaining_next = pulses_remaining - PULSE_W'(1);
          phase_next            = PH_ALERT_ON;
          ticks_remaining_next  = alert_on_ticks;
        end else begin
          // A gap has ended or the sequencer is idle: pick the next job.
          // A queued alert wins over queued beeps.
          if (phase_now == PH_ALERT_GAP) begin
            alert_in_progress_next = 1'b0;
          end
          if (alert_requested) begin
            alert_requested_next   = 1'b0;
            alert_in_progress_next = 1'b1;
            pulses_remaining_next  = PULSE_W'(pulse_total_clamped - PULSE_TOT_W'(1));
            phase_next             = PH_ALERT_ON;
            ticks_remaining_next   = alert_on_ticks;
          end else if (beep_queue_count != '0) begin
            beep_queue_count_next = beep_queue_count - CNT_W'(1);
            phase_next            = PH_BEEP_ON;
            ticks_remaining_next  = beep_on_ticks;
          end else begin
            phase_next           = PH_IDLE;
            ticks_remaining_next = '0;
          end
        end
      end
      OP_BEEP: begin
        if (beep_queue_count < CNT_W'(QUEUE_LIMIT)) begin
          beep_queue_count_next = beep_queue_count + CNT_W'(1);
          result_next           = BEEP_ACCEPT;
        end else begin
          result_next = BEEP_REFUSED;
        end
      end
      OP_LINK: begin
        if (32'(link_index) < LINK_COUNT) begin
          // Only an up-to-down change counts as a loss.
          link_lost = link_state[link_index[LINK_IDX_W-1:0]] && !link_up;
          link_state_next[link_index[LINK_IDX_W-1:0]] = link_up;
          if (link_lost && !outage_latched) begin
            // First loss of this outage episode; no new alert while one sounds.
            if (!alert_in_progress) begin
              alert_requested_next = 1'b1;
            end
            outage_latched_next = 1'b1;
          end
          // The episode ends once the wireless and broker links are both up.
          if (link_state_next[0] && link_state_next[1]) begin
            outage_latched_next = 1'b0;
          end
        end
      end
      default: begin
        // Unused operation code: no state change.
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      beep_on_ticks     <= BEEP_ON_RST;
      beep_gap_ticks    <= BEEP_GAP_RST;
      alert_on_ticks    <= ALERT_ON_RST;
      alert_gap_ticks   <= ALERT_GAP_RST;
      alert_pulse_total <= PULSE_TOTAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BEEP_ON:     beep_on_ticks     <= cfg_data;
        CFG_BEEP_GAP:    beep_gap_ticks    <= cfg_data;
        CFG_ALERT_ON:    alert_on_ticks    <= cfg_data;
        CFG_ALERT_GAP:   alert_gap_ticks   <= cfg_data;
        CFG_PULSE_TOTAL: alert_pulse_total <= cfg_data[PULSE_TOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_now         <= PH_IDLE;
      ticks_remaining   <= '0;
      pulses_remaining  <= '0;
      beep_queue_count  <= '0;
      alert_requested   <= 1'b0;
      alert_in_progress <= 1'b0;
      outage_latched    <= 1'b0;
      link_state        <= '0;
    end else if (accept) begin
      phase_now         <= phase_next;
      ticks_remaining   <= ticks_remaining_next;
      pulses_remaining  <= pulses_remaining_next;
      beep_queue_count  <= beep_queue_count_next;
      alert_requested   <= alert_requested_next;
      alert_in_progress <= alert_in_progress_next;
      outage_latched    <= outage_latched_next;
      link_state        <= link_state_next;
    end
  end

  // Result register: valid flag under reset, payload loaded on each accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buzzer_on      <= (phase_next == PH_BEEP_ON) || (phase_next == PH_ALERT_ON);
      beep_result    <= result_next;
      alert_sounding <= alert_in_progress_next;
      beeps_waiting  <= WAITING_W'(beep_queue_count_next);
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the beep and alert sequencer: event stimulus, shadow predictor and result checks.
`timescale 1ns / 100ps

module tb_top;
  import bas_pkg::*;

  // Operation code three is not defined; the block must leave its state alone for it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int SEGMENT_WORDS = 220;
  localparam int SEGMENT_COUNT = 6;
  localparam int MISMATCH_REPORTS = 10;

  // One result word as the sequencer reports it after an event.
  typedef struct packed {
    logic                 buzzer;
    logic [1:0]           beep_res;
    logic                 alerting;
    logic [WAITING_W-1:0] waiting;
  } seq_report_t;

  // The scoreboard keeps its own copy of the timing registers and of the sequencer
  // state, predicts the result word of every accepted event word and checks the
  // result words in order against those predictions.
  class sequencer_scoreboard;
    logic [TICK_W-1:0]      beep_on, beep_gap, alert_sound_len, alert_quiet_len;
    logic [PULSE_TOT_W-1:0] pulse_total;
    phase_t                 phase;
    logic [TICK_W-1:0]      ticks_left;
    logic [PULSE_W-1:0]     pulse_budget;
    logic [WAITING_W-1:0]   beep_count;
    logic                   alert_pending, alert_busy, outage_seen;
    logic [LINK_COUNT_DEF-1:0] link_ok;
    seq_report_t            reports_due[$];
    int                     mismatches;

    function new();
      beep_on         = BEEP_ON_RST;
      beep_gap        = BEEP_GAP_RST;
      alert_sound_len = ALERT_ON_RST;
      alert_quiet_len = ALERT_GAP_RST;
      pulse_total     = PULSE_TOTAL_RST;
      phase           = PH_IDLE;
      ticks_left      = '0;
      pulse_budget    = '0;
      beep_count      = '0;
      alert_pending   = 1'b0;
      alert_busy      = 1'b0;
      outage_seen     = 1'b0;
      link_ok         = '0;
      mismatches      = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_BEEP_ON:     beep_on = data;
        CFG_BEEP_GAP:    beep_gap = data;
        CFG_ALERT_ON:    alert_sound_len = data;
        CFG_ALERT_GAP:   alert_quiet_len = data;
        CFG_PULSE_TOTAL: pulse_total = data[PULSE_TOT_W-1:0];
        default: ;
      endcase
    endfunction

    function void start_phase(phase_t next_phase, logic [TICK_W-1:0] ticks);
      phase = next_phase;
      ticks_left = ticks;
    endfunction

    // A tick runs the current phase down; a phase that reaches its end (a length
    // of zero behaves as one) hands over to the next gap, pulse, alert or beep.
    function void apply_tick();
      logic [PULSE_TOT_W-1:0] total;
      if (phase != PH_IDLE) begin
        if (ticks_left > 1) begin
          ticks_left = ticks_left - 1'b1;
          return;
        end
        ticks_left = '0;
      end
      if (phase == PH_BEEP_ON) begin
        start_phase(PH_BEEP_GAP, beep_gap);
        return;
      end
      if (phase == PH_ALERT_ON) begin
        start_phase(PH_ALERT_GAP, alert_quiet_len);
        return;
      end
      if (phase == PH_ALERT_GAP && pulse_budget != 0) begin
        pulse_budget = pulse_budget - 1'b1;
        start_phase(PH_ALERT_ON, alert_sound_len);
        return;
      end
      if (phase == PH_ALERT_GAP)
        alert_busy = 1'b0;
      if (alert_pending) begin
        total = pulse_total;
        if (total == 0)
          total = PULSE_TOT_W'(1);
        if (total > PULSE_TOTAL_MAX)
          total = PULSE_TOTAL_MAX;
        alert_pending = 1'b0;
        alert_busy    = 1'b1;
        pulse_budget  = PULSE_W'(total - 1'b1);
        start_phase(PH_ALERT_ON, alert_sound_len);
      end else if (beep_count != 0) begin
        beep_count = beep_count - 1'b1;
        start_phase(PH_BEEP_ON, beep_on);
      end else begin
        phase = PH_IDLE;
        ticks_left = '0;
      end
    endfunction

    // Only an up-to-down change is a loss, and only the first loss of an outage
    // episode raises an alert, and then only when none is sounding.
    function void apply_link(logic [1:0] idx, logic up);
      logic lost;
      if (idx >= LINK_COUNT_DEF)
        return;
      lost = link_ok[idx[0]] && !up;
      link_ok[idx[0]] = up;
      if (lost && !outage_seen) begin
        if (!alert_busy)
          alert_pending = 1'b1;
        outage_seen = 1'b1;
      end
      if (link_ok[0] && link_ok[1])
        outage_seen = 1'b0;
    endfunction

    function void note_event(logic [1:0] op, logic [1:0] idx, logic up);
      seq_report_t rep;
      rep.beep_res = BEEP_NONE;
      case (op)
        OP_TICK: apply_tick();
        OP_BEEP: begin
          if (beep_count < QUEUE_LIMIT_DEF) begin
            beep_count = beep_count + 1'b1;
            rep.beep_res = BEEP_ACCEPT;
          end else begin
            rep.beep_res = BEEP_REFUSED;
          end
        end
        OP_LINK: apply_link(idx, up);
        default: ;
      endcase
      rep.buzzer   = (phase == PH_BEEP_ON || phase == PH_ALERT_ON);
      rep.alerting = alert_busy;
      rep.waiting  = beep_count;
      reports_due.push_back(rep);
    endfunction

    function void check_report(seq_report_t got);
      seq_report_t due;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_REPORTS)
          $display("[%0t] unexpected result word: buzzer=%0d result=%0d alert=%0d waiting=%0d",
                   $time, got.buzzer, got.beep_res, got.alerting, got.waiting);
        return;
      end
      due = reports_due.pop_front();
      if (got.buzzer !== due.buzzer || got.beep_res !== due.beep_res ||
          got.alerting !== due.alerting || got.waiting !== due.waiting) begin
        mismatches++;
        if (mismatches <= MISMATCH_REPORTS) begin
          $display("[%0t] mismatch: expected buzzer=%0d result=%0d alert=%0d waiting=%0d",
                   $time, due.buzzer, due.beep_res, due.alerting, due.waiting);
          $display("[%0t]           got      buzzer=%0d result=%0d alert=%0d waiting=%0d",
                   $time, got.buzzer, got.beep_res, got.alerting, got.waiting);
        end
      end
    endfunction
  endclass

  // Every input of the block starts at a known value; reset is high from time zero.
  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             operation = '0;
  logic [1:0]             link_index = '0;
  logic                   link_up = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   buzzer_on;
  logic [1:0]             beep_result;
  logic                   alert_sounding;
  logic [WAITING_W-1:0]   beeps_waiting;

  // Percent chance, per cycle, that the sender holds off a word or the receiver stalls.
  int send_idle_pct = 32;
  int recv_idle_pct = 74;

  sequencer_scoreboard board;

  beep_and_alert_sequencer dut (.*);

  // 4 ns clock, first rising edge at 2 ns.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The receiver decides at each falling edge whether it takes a word at the next
  // rising edge, so stalls land on every phase of the sequencer's work.
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // Every result word taken at a rising edge is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_report(seq_report_t'{buzzer_on, beep_result, alert_sounding, beeps_waiting});
  end

  // Presents one event word from a falling edge, after a random hold-off, and keeps
  // it steady until the handshake completes. The prediction is made at acceptance.
  task automatic send_word(input logic [1:0] op, input logic [1:0] idx, input logic up);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    link_index <= idx;
    link_up    <= up;
    do @(posedge clk); while (!in_ready);
    board.note_event(op, idx, up);
  endtask

  // Mostly ticks so that sequences play out, with beeps to fill the queue and link
  // changes on the two real links to start and end outage episodes. Unused fields
  // carry random bits, and a few words use the undefined operation or a link index
  // beyond the link count.
  task automatic send_random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_word(OP_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)));
    else if (pick < 70)
      send_word(OP_BEEP, 2'($urandom_range(3)), 1'($urandom_range(1)));
    else if (pick < 95)
      send_word(OP_LINK,
                ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1)),
                1'($urandom_range(1)));
    else
      send_word(OP_UNUSED, 2'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  // Stops the event stream, waits until every predicted word has been checked,
  // then waits on with some margin.
  task automatic drain_sequencer();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.reports_due.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    board.write_reg(index, data);
  endtask

  // Writes all five timing registers back to back while no event words are sent.
  task automatic load_timings(input logic [CFG_DATA_W-1:0] b_on, b_gap, a_on, a_gap, pulses);
    write_register(CFG_BEEP_ON, b_on);
    write_register(CFG_BEEP_GAP, b_gap);
    write_register(CFG_ALERT_ON, a_on);
    write_register(CFG_ALERT_GAP, a_gap);
    write_register(CFG_PULSE_TOTAL, pulses);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int seg;
    board = new();

    // Synchronous reset held from time zero, then released at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset timings. An undefined operation, a drop on a
    // link that is already down, an index beyond the link count, then both links
    // up and a first loss that queues an alert.
    send_word(OP_UNUSED, 2'd3, 1'b1);
    send_word(OP_LINK, 2'd0, 1'b0);
    send_word(OP_LINK, 2'd3, 1'b1);
    send_word(OP_LINK, 2'd0, 1'b1);
    send_word(OP_LINK, 2'd1, 1'b1);
    send_word(OP_LINK, 2'd0, 1'b0);
    // Seventeen beep requests: the queue fills at sixteen and the last is refused.
    repeat (QUEUE_LIMIT_DEF + 1) send_word(OP_BEEP, 2'd1, 1'b0);
    // A tick while idle starts the queued alert ahead of the beeps at once.
    send_word(OP_TICK, 2'd2, 1'b1);
    // Both links up ends the episode; a new loss while the alert sounds is suppressed.
    send_word(OP_LINK, 2'd0, 1'b1);
    send_word(OP_LINK, 2'd1, 1'b0);
    send_word(OP_TICK, 2'd0, 1'b0);

    // Random segments. Idling goes sender-light and receiver-heavy first, then the
    // other way round, then none at all; each segment starts from a new timing set.
    for (seg = 0; seg < SEGMENT_COUNT; seg++) begin
      drain_sequencer();
      case (seg / 2)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        // Zero lengths behave as one tick and a pulse total of zero as one pulse.
        0: load_timings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // Longest phases; a pulse total of fifteen is held to eight. The upper bits
        // of the write data do not belong to the four-bit pulse register.
        1: load_timings(8'd255, 8'd255, 8'd255, 8'd255, {4'($urandom_range(15)), 4'd15});
        // Shortest legal phases with the most pulses.
        3: load_timings(8'd1, 8'd1, 8'd1, 8'd1, 8'd8);
        default: load_timings(8'($urandom_range(6)), 8'($urandom_range(6)),
                              8'($urandom_range(6)), 8'($urandom_range(6)),
                              {4'($urandom_range(15)), 4'($urandom_range(15))});
      endcase
      repeat (SEGMENT_WORDS) send_random_word();
    end

    drain_sequencer();
    repeat (8) @(posedge clk);

    if (board.mismatches == 0 && board.reports_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run under the heaviest idling.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
